// ----- design/tick_clock_with_stopwatch_slots_macros.svh -----
// ----------------------------------------------------------------------------
// tick clock assertion macros
// shared concurrent assertion forms, clocked and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TICK_CLOCK_WITH_STOPWATCH_SLOTS_MACROS_SVH
`define TICK_CLOCK_WITH_STOPWATCH_SLOTS_MACROS_SVH

// same-cycle implication
`define TCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// types and constants shared by the tick clock modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcs_pkg;

    // item codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // reset ticks per second
    localparam logic [15:0] TPS_RESET = 16'd488;

    // last value of each time-of-day digit
    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    // time view after one step
    typedef struct packed {
        logic        second_pulse;
        logic        minute_pulse;
        logic [5:0]  sec_of_min;
        logic [5:0]  min_of_hour;
        logic [4:0]  hour_of_day;
        logic [31:0] seconds;
        logic [31:0] minutes;
    } t_time;

endpackage

// ----- design/tcs_timebase.sv -----
// ----------------------------------------------------------------------------
// tcs_timebase
// prescaler, seconds and minutes counts, and time-of-day digits kept in step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tick_clock_with_stopwatch_slots_macros.svh"

module tcs_timebase (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output tcs_pkg::t_time     o_now
);

    logic [15:0] r_tps;
    logic [15:0] r_presc, n_presc;
    logic [31:0] r_seconds, n_seconds;
    logic [31:0] r_minutes, n_minutes;
    logic [5:0]  r_sec_of_min, n_sec_of_min;
    logic [5:0]  r_min_of_hour, n_min_of_hour;
    logic [4:0]  r_hour_of_day, n_hour_of_day;
    logic [15:0] w_presc_inc;
    logic        w_sec_done;
    logic        n_second_pulse;
    logic        n_minute_pulse;

    assign w_presc_inc = r_presc + 16'd1;
    assign w_sec_done  = (w_presc_inc >= r_tps);

    // next counts for a tick; digits track seconds exactly, wrap clears them
    always_comb begin
        n_presc        = r_presc;
        n_seconds      = r_seconds;
        n_minutes      = r_minutes;
        n_sec_of_min   = r_sec_of_min;
        n_min_of_hour  = r_min_of_hour;
        n_hour_of_day  = r_hour_of_day;
        n_second_pulse = 1'b0;
        n_minute_pulse = 1'b0;
        if (i_tick) begin
            if (w_sec_done) begin
                n_presc        = '0;
                n_seconds      = r_seconds + 32'd1;
                n_second_pulse = 1'b1;
                if (r_seconds == '1) begin
                    n_sec_of_min  = '0;
                    n_min_of_hour = '0;
                    n_hour_of_day = '0;
                end else if (r_sec_of_min == tcs_pkg::SEC_LAST) begin
                    n_sec_of_min   = '0;
                    n_minutes      = r_minutes + 32'd1;
                    n_minute_pulse = 1'b1;
                    if (r_min_of_hour == tcs_pkg::MIN_LAST) begin
                        n_min_of_hour = '0;
                        if (r_hour_of_day == tcs_pkg::HOUR_LAST) begin
                            n_hour_of_day = '0;
                        end else begin
                            n_hour_of_day = r_hour_of_day + 5'd1;
                        end
                    end else begin
                        n_min_of_hour = r_min_of_hour + 6'd1;
                    end
                end else begin
                    n_sec_of_min = r_sec_of_min + 6'd1;
                end
            end else begin
                n_presc = w_presc_inc;
            end
        end
    end

    // counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps         <= tcs_pkg::TPS_RESET;
            r_presc       <= '0;
            r_seconds     <= '0;
            r_minutes     <= '0;
            r_sec_of_min  <= '0;
            r_min_of_hour <= '0;
            r_hour_of_day <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_data;
            end
            r_presc       <= n_presc;
            r_seconds     <= n_seconds;
            r_minutes     <= n_minutes;
            r_sec_of_min  <= n_sec_of_min;
            r_min_of_hour <= n_min_of_hour;
            r_hour_of_day <= n_hour_of_day;
        end
    end

    // view after this step
    always_comb begin
        o_now.second_pulse = n_second_pulse;
        o_now.minute_pulse = n_minute_pulse;
        o_now.sec_of_min   = n_sec_of_min;
        o_now.min_of_hour  = n_min_of_hour;
        o_now.hour_of_day  = n_hour_of_day;
        o_now.seconds      = n_seconds;
        o_now.minutes      = n_minutes;
    end

    // checks
    `TCS_ASSERT_NOW(a_min_needs_sec, i_clk, i_rst_n, n_minute_pulse, n_second_pulse, "minute pulse without second pulse")
    `TCS_ASSERT_NEXT(a_presc_clear, i_clk, i_rst_n, i_tick && w_sec_done, r_presc == 16'd0, "prescaler not cleared after second")
    `TCS_ASSERT_NEXT(a_hold_no_tick, i_clk, i_rst_n, !i_tick, $stable(r_seconds) && $stable(r_minutes), "counts moved without tick")

endmodule

// ----- design/tcs_slots.sv -----
// ----------------------------------------------------------------------------
// tcs_slots
// stopwatch start store with per-entry valid bits and registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcs_slots #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_slot,
    input  logic        i_we,
    input  logic [31:0] i_wdata,
    input  logic        i_re,
    output logic [31:0] o_rdata
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [7:0] SLOT_LIMIT = 8'(NUM_SLOTS);

    logic [31:0]          r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    logic [31:0]          r_rd_data;
    logic                 r_rd_vld;
    logic [IW-1:0]        w_idx;

    // out-of-range index falls back to slot 0
    assign w_idx = (i_slot < SLOT_LIMIT) ? i_slot[IW-1:0] : '0;

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[w_idx] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[w_idx];
        end
    end

    // valid bits; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[w_idx] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[w_idx];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- design/tick_clock_with_stopwatch_slots.sv -----
// ----------------------------------------------------------------------------
// tick_clock_with_stopwatch_slots
// prescaled seconds counter with minute count, time of day and stopwatches
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall    i_op, i_slot
// result    out        o_out_valid / i_out_stall  pulses, time of day, totals, elapsed
// config    in         i_cfg_we                   i_cfg_data (ticks per second)
//
// one word accepted per cycle while the intake is not stalled; its result is
// registered in the stage register (slot store read), then the output register
// synchronous active-low reset clears counts, slot valid bits and both stages
// a stalled output holds; intake stalls only when both registers are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tick_clock_with_stopwatch_slots_macros.svh"

module tick_clock_with_stopwatch_slots #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_second_pulse,
    output logic        o_minute_pulse,
    output logic [5:0]  o_seconds_of_minute,
    output logic [5:0]  o_minutes_of_hour,
    output logic [4:0]  o_hours_of_day,
    output logic [31:0] o_total_seconds,
    output logic [31:0] o_total_minutes,
    output logic [31:0] o_elapsed
);

    logic           w_in_acc;
    logic           w_s1_adv;
    tcs_pkg::t_time w_now;
    logic [31:0]    w_start;
    logic [31:0]    n_elapsed;

    logic           r_s1_valid;
    logic           r_s1_read;
    tcs_pkg::t_time r_s1_time;

    logic           r_out_valid;
    tcs_pkg::t_time r_out_time;
    logic [31:0]    r_out_elapsed;

    // handshake
    assign w_s1_adv   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !w_s1_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // counters
    tcs_timebase u_timebase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_in_acc && (i_op == tcs_pkg::OP_TICK)),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_now      (w_now)
    );

    // stopwatch starts
    tcs_slots #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (i_slot),
        .i_we    (w_in_acc && (i_op == tcs_pkg::OP_START)),
        .i_wdata (w_now.seconds),
        .i_re    (w_in_acc),
        .o_rdata (w_start)
    );

    // stage register: time snapshot after the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_read <= (i_op == tcs_pkg::OP_READ);
            r_s1_time <= w_now;
        end
    end

    // elapsed seconds on a read, zero unless the start is earlier
    always_comb begin
        n_elapsed = '0;
        if (r_s1_read && (w_start < r_s1_time.seconds)) begin
            n_elapsed = r_s1_time.seconds - w_start;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_out_time    <= r_s1_time;
            r_out_elapsed <= n_elapsed;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_second_pulse      = r_out_time.second_pulse;
    assign o_minute_pulse      = r_out_time.minute_pulse;
    assign o_seconds_of_minute = r_out_time.sec_of_min;
    assign o_minutes_of_hour   = r_out_time.min_of_hour;
    assign o_hours_of_day      = r_out_time.hour_of_day;
    assign o_total_seconds     = r_out_time.seconds;
    assign o_total_minutes     = r_out_time.minutes;
    assign o_elapsed           = r_out_elapsed;

    // checks
    `TCS_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_valid && !w_s1_adv, r_s1_valid, "stage word lost under stall")
    `TCS_ASSERT_NOW(a_minute_on_zero, i_clk, i_rst_n, o_out_valid && o_minute_pulse, o_seconds_of_minute == 6'd0, "minute pulse off the minute")
    `TCS_ASSERT_NOW(a_elapsed_read_only, i_clk, i_rst_n, r_s1_valid && !r_s1_read, n_elapsed == 32'd0, "elapsed on a non-read word")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives ticks, stopwatch starts and reads into the tick clock with random
// gaps and output stalls, predicts every result word in step with the
// accepted input words and compares each result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int          SLOTS        = 8;
    localparam logic [1:0]  OP_NONE      = 2'd3;
    localparam int          IDLE_PCT     = 35;
    localparam int          RANDOM_WORDS = 1750;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          DRAIN_CYCLES = 4;
    localparam logic [31:0] SEC_PER_MIN  = 32'd60;
    localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
    localparam logic [31:0] HOURS_PER_DAY = 32'd24;

    // one result word: time view plus stopwatch reading
    typedef struct packed {
        tcs_pkg::t_time view;
        logic [31:0]    elapsed;
    } t_clock_word;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [1:0]  in_op     = tcs_pkg::OP_TICK;
    logic [7:0]  in_slot   = '0;
    logic        out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_second_pulse;
    logic        o_minute_pulse;
    logic [5:0]  o_seconds_of_minute;
    logic [5:0]  o_minutes_of_hour;
    logic [4:0]  o_hours_of_day;
    logic [31:0] o_total_seconds;
    logic [31:0] o_total_minutes;
    logic [31:0] o_elapsed;

    // predicted clock state
    logic [15:0] rate_ticks;
    logic [15:0] prescale;
    logic [31:0] sec_total;
    logic [31:0] min_total;
    logic [31:0] slot_mark [SLOTS];

    t_clock_word clock_expected [$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    bit          steady_flow = 1'b0;

    always #5 clk = ~clk;

    tick_clock_with_stopwatch_slots #(
        .NUM_SLOTS(SLOTS)
    ) i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (in_op),
        .i_slot              (in_slot),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (out_stall),
        .o_second_pulse      (o_second_pulse),
        .o_minute_pulse      (o_minute_pulse),
        .o_seconds_of_minute (o_seconds_of_minute),
        .o_minutes_of_hour   (o_minutes_of_hour),
        .o_hours_of_day      (o_hours_of_day),
        .o_total_seconds     (o_total_seconds),
        .o_total_minutes     (o_total_minutes),
        .o_elapsed           (o_elapsed)
    );

    // apply one word to the predicted state and return its result word
    function automatic t_clock_word advance_clock(input logic [1:0] op, input logic [7:0] slot);
        t_clock_word w;
        logic [15:0] next_count;
        int          idx;
        w   = '0;
        idx = (slot < SLOTS) ? int'(slot) : 0;
        case (op)
            tcs_pkg::OP_TICK: begin
                next_count = prescale + 16'd1;
                if (next_count >= rate_ticks) begin
                    sec_total = sec_total + 32'd1;
                    if (sec_total != 32'd0 && sec_total % SEC_PER_MIN == 32'd0) begin
                        min_total = min_total + 32'd1;
                        w.view.minute_pulse = 1'b1;
                    end
                    w.view.second_pulse = 1'b1;
                    next_count = '0;
                end
                prescale = next_count;
            end
            tcs_pkg::OP_START: begin
                slot_mark[idx] = sec_total;
            end
            tcs_pkg::OP_READ: begin
                if (slot_mark[idx] < sec_total) w.elapsed = sec_total - slot_mark[idx];
            end
            default: begin
            end
        endcase
        w.view.sec_of_min  = 6'(sec_total % SEC_PER_MIN);
        w.view.min_of_hour = 6'((sec_total / SEC_PER_MIN) % SEC_PER_MIN);
        w.view.hour_of_day = 5'((sec_total / SEC_PER_HOUR) % HOURS_PER_DAY);
        w.view.seconds     = sec_total;
        w.view.minutes     = min_total;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // send one word, with a random gap ahead of it
    task automatic send_word(input logic [1:0] op, input logic [7:0] slot);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_slot  <= slot;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        clock_expected.push_back(advance_clock(op, slot));
    endtask

    // hold off input until every predicted word has come out
    task automatic wait_drain;
        in_valid <= 1'b0;
        while (clock_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_rate(input logic [15:0] tps);
        wait_drain();
        cfg_we   <= 1'b1;
        cfg_data <= tps;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rate_ticks = tps;
    endtask

    // counts right after reset, including never-written slots
    task automatic test_reset_state;
        send_word(tcs_pkg::OP_TICK, 8'd0);
        send_word(tcs_pkg::OP_TICK, 8'd0);
        send_word(tcs_pkg::OP_READ, 8'd0);
        send_word(tcs_pkg::OP_READ, 8'(SLOTS - 1));
        send_word(OP_NONE, 8'd255);
    endtask

    // largest rate, rate lowered below the prescaler, zero rate, rate of one
    task automatic test_rate_extremes;
        set_rate(16'hFFFF);
        send_word(tcs_pkg::OP_TICK, 8'd0);
        send_word(tcs_pkg::OP_TICK, 8'd0);
        set_rate(16'd3);
        send_word(tcs_pkg::OP_TICK, 8'd0);
        set_rate(16'd0);
        send_word(tcs_pkg::OP_TICK, 8'd0);
        send_word(tcs_pkg::OP_TICK, 8'd0);
        set_rate(16'd1);
        send_word(tcs_pkg::OP_TICK, 8'd0);
    endtask

    // slot select, out-of-range slots and a read with no time passed
    task automatic test_slot_select;
        send_word(tcs_pkg::OP_START, 8'd3);
        send_word(tcs_pkg::OP_READ, 8'd3);
        send_word(tcs_pkg::OP_START, 8'd255);
        send_word(tcs_pkg::OP_TICK, 8'd0);
        send_word(tcs_pkg::OP_READ, 8'd3);
        send_word(tcs_pkg::OP_READ, 8'd200);
        send_word(tcs_pkg::OP_START, 8'(SLOTS));
        send_word(tcs_pkg::OP_READ, 8'd0);
        send_word(tcs_pkg::OP_READ, 8'(SLOTS - 1));
    endtask

    task automatic test_unused_op;
        send_word(OP_NONE, 8'd0);
        send_word(OP_NONE, 8'd170);
    endtask

    // phases of random words, each under a freshly picked rate
    task automatic test_random_traffic;
        int          sent;
        int          phase;
        int          roll;
        logic [15:0] rate;
        logic [1:0]  op;
        logic [7:0]  slot;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            // mostly small rates so that seconds and minutes roll over often
            roll = $urandom_range(99);
            if (roll < 70) rate = 16'($urandom_range(3));
            else if (roll < 90) rate = 16'($urandom_range(20, 4));
            else if (roll < 95) rate = 16'hFFFF;
            else rate = 16'($urandom_range(65535, 1000));
            set_rate(rate);
            steady_flow = (phase == 3);
            repeat ($urandom_range(160, 60)) begin
                roll = $urandom_range(99);
                if (roll < 60) op = tcs_pkg::OP_TICK;
                else if (roll < 77) op = tcs_pkg::OP_START;
                else if (roll < 96) op = tcs_pkg::OP_READ;
                else op = OP_NONE;
                roll = $urandom_range(99);
                if (roll < 75) slot = 8'($urandom_range(SLOTS - 1));
                else if (roll < 90) slot = 8'($urandom_range(SLOTS + 7, SLOTS));
                else slot = 8'($urandom);
                send_word(op, slot);
                sent++;
                if ($urandom_range(199) == 0) wait_drain();
            end
            phase++;
        end
        steady_flow = 1'b0;
    endtask

    // output stall driver
    always @(posedge clk) begin
        out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
    end

    // compare each result word with the oldest prediction
    always @(posedge clk) begin : result_check
        t_clock_word want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (clock_expected.size() == 0) begin
                $display("%0t: result word with none expected, expected none, actual seconds %0d",
                         $time, o_total_seconds);
                fail_count++;
            end else begin
                want = clock_expected.pop_front();
                check_field("second_pulse", 32'(want.view.second_pulse), 32'(o_second_pulse));
                check_field("minute_pulse", 32'(want.view.minute_pulse), 32'(o_minute_pulse));
                check_field("seconds_of_minute", 32'(want.view.sec_of_min),
                            32'(o_seconds_of_minute));
                check_field("minutes_of_hour", 32'(want.view.min_of_hour),
                            32'(o_minutes_of_hour));
                check_field("hours_of_day", 32'(want.view.hour_of_day), 32'(o_hours_of_day));
                check_field("total_seconds", want.view.seconds, o_total_seconds);
                check_field("total_minutes", want.view.minutes, o_total_minutes);
                check_field("elapsed", want.elapsed, o_elapsed);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        rate_ticks = tcs_pkg::TPS_RESET;
        prescale   = '0;
        sec_total  = '0;
        min_total  = '0;
        for (int i = 0; i < SLOTS; i++) slot_mark[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_rate_extremes();
        test_slot_select();
        test_unused_op();
        test_random_traffic();
        wait_drain();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/tcs_pkg.sv
design/tcs_timebase.sv
design/tcs_slots.sv
design/tick_clock_with_stopwatch_slots.sv
verif/testbench.sv
